### sv/tkb_pkg.sv
package tkb_pkg;

    // command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_SWEEP  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_ENTRIES    = 2'd0;
    localparam logic [1:0] REG_KEY_BYTES      = 2'd1;
    localparam logic [1:0] REG_EXPIRE_SECONDS = 2'd2;

    // status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // entry word layout: valid, key, expiry, size
    localparam int unsigned WORD_W = 129;
    localparam int unsigned VLD_B  = 128;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [31:0] expiry;
        logic [31:0] size;
    } t_entry;

    typedef struct packed {
        logic        status;
        logic        hit;
        logic [8:0]  occupancy;
    } t_result;

    // comparison mask from key byte count, clamped to 1..8
    function automatic logic [63:0] key_mask(input logic [3:0] kb);
        logic [63:0] m;
        m = '0;
        case (kb)
            4'd0, 4'd1: m = 64'h0000_0000_0000_00FF;
            4'd2:       m = 64'h0000_0000_0000_FFFF;
            4'd3:       m = 64'h0000_0000_00FF_FFFF;
            4'd4:       m = 64'h0000_0000_FFFF_FFFF;
            4'd5:       m = 64'h0000_00FF_FFFF_FFFF;
            4'd6:       m = 64'h0000_FFFF_FFFF_FFFF;
            4'd7:       m = 64'h00FF_FFFF_FFFF_FFFF;
            default:    m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

### sv/tkb_ifs.sv
interface tkb_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [31:0] value_size;
    logic [31:0] now;
    modport source (output valid, cmd, key, value_size, now, input ready);
    modport sink   (input valid, cmd, key, value_size, now, output ready);
endinterface

interface tkb_res_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic       hit;
    logic [8:0] occupancy;
    modport source (output valid, status, hit, occupancy, input ready);
    modport sink   (input valid, status, hit, occupancy, output ready);
endinterface

interface tkb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/ttl_key_blacklist_table.sv
// Key table with time-to-live expiry. Every item (add, lookup, sweep) walks the whole
// entry memory through its single read port, one entry a cycle. The result passes
// through the walk, a write-back step and the load of the output register, which waits
// while an earlier result is still held. Unused command 3 skips the walk. The input is
// ready only while idle, so a new item is accepted only after the last one has loaded
// its result. After reset the block clears the memory and accepts no item meanwhile;
// configuration writes are always taken. The result is held in an output register, so
// the next item is accepted while an earlier result waits.
module ttl_key_blacklist_table #(
    parameter int unsigned ENTRIES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tkb_cmd_if.sink   i_in,
    tkb_res_if.source o_res,
    tkb_cfg_if.sink   i_cfg
);
    import tkb_pkg::*;

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam logic [AW:0] LAST = (AW+1)'(ENTRIES - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    r_state;
    logic [AW:0]   r_addr;
    logic          r_issue_end;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_addr;
    logic [CW-1:0] r_count;
    logic [8:0]    r_max_entries;
    logic [3:0]    r_key_bytes;
    logic [31:0]   r_expire;
    logic [1:0]    r_cmd;
    logic [63:0]   r_key;
    logic [31:0]   r_size;
    logic [31:0]   r_now;
    logic [31:0]   r_exp;
    logic [63:0]   r_mask;
    logic          r_found;
    logic [AW-1:0] r_match_addr;
    logic [63:0]   r_match_key;
    logic          r_free_found;
    logic [AW-1:0] r_free_addr;
    t_result       r_res;
    t_result       r_out;
    logic          r_o_valid;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          mem_re;
    t_entry        rd_entry;
    logic [WORD_W-1:0] rd_word;
    logic          in_acc;
    logic          match;
    logic          expired;
    logic [31:0]   limit;
    logic          load_out;

    tkb_mem #(.DEPTH(ENTRIES), .AW(AW), .DW(WORD_W)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(r_addr[AW-1:0]),
        .o_rdata(rd_word)
    );

    assign rd_entry = rd_word;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign load_out    = (r_state == S_DONE) && (!r_o_valid || o_res.ready);

    // per entry tests during the walk
    assign match   = rd_entry.valid && (((rd_entry.key ^ r_key) & r_mask) == 64'd0);
    assign expired = rd_entry.valid && (rd_entry.expiry <= r_now);
    assign limit   = (32'(r_max_entries) < 32'(ENTRIES)) ? 32'(r_max_entries)
                                                         : 32'(ENTRIES);
    assign mem_re  = (r_state == S_SCAN) && !r_issue_end;

    // memory write selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_rd_addr;
        mem_wdata = rd_entry;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr[AW-1:0];
                mem_wdata = '0;
            end
            S_SCAN: begin
                mem_wdata.valid = 1'b0;
                mem_we = r_rd_vld && (r_cmd == CMD_SWEEP) && expired;
            end
            S_WR: begin
                mem_wdata.valid  = 1'b1;
                mem_wdata.expiry = r_exp;
                mem_wdata.size   = r_size;
                if (r_found) begin
                    mem_waddr     = r_match_addr;
                    mem_wdata.key = r_match_key;
                    mem_we        = (r_cmd == CMD_ADD);
                end else begin
                    mem_waddr     = r_free_addr;
                    mem_wdata.key = r_key;
                    mem_we        = (r_cmd == CMD_ADD) && r_free_found
                                    && (32'(r_count) < limit);
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= 9'd256;
            r_key_bytes   <= 4'd4;
            r_expire      <= 32'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MAX_ENTRIES:    r_max_entries <= i_cfg.data[8:0];
                REG_KEY_BYTES:      r_key_bytes   <= i_cfg.data[3:0];
                REG_EXPIRE_SECONDS: r_expire      <= i_cfg.data;
                default:            r_expire      <= r_expire;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_in.cmd;
            r_key  <= i_in.key;
            r_size <= i_in.value_size;
            r_now  <= i_in.now;
            r_exp  <= i_in.now + r_expire;
            r_mask <= key_mask(r_key_bytes);
        end
        if (r_state == S_SCAN && r_rd_vld && match && !r_found) begin
            r_match_addr <= r_rd_addr;
            r_match_key  <= rd_entry.key;
        end
        if (r_state == S_SCAN && r_rd_vld && !rd_entry.valid && !r_free_found) begin
            r_free_addr <= r_rd_addr;
        end
        r_rd_addr <= r_addr[AW-1:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_addr       <= '0;
            r_issue_end  <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_count      <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_res        <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_addr       <= '0;
                    r_issue_end  <= 1'b0;
                    r_rd_vld     <= 1'b0;
                    r_found      <= 1'b0;
                    r_free_found <= 1'b0;
                    r_res        <= '0;
                    if (in_acc) begin
                        r_state <= (i_in.cmd == CMD_ADD || i_in.cmd == CMD_LOOKUP
                                    || i_in.cmd == CMD_SWEEP) ? S_SCAN : S_WR;
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= mem_re;
                    if (mem_re) begin
                        r_addr <= r_addr + 1'b1;
                        if (r_addr == LAST) begin
                            r_issue_end <= 1'b1;
                        end
                    end
                    if (r_rd_vld) begin
                        if (match) begin
                            r_found <= 1'b1;
                        end
                        if (!rd_entry.valid) begin
                            r_free_found <= 1'b1;
                        end
                        if (mem_we && r_count != '0) begin
                            r_count <= r_count - 1'b1;
                        end
                        if ({1'b0, r_rd_addr} == LAST) begin
                            r_state <= S_WR;
                        end
                    end
                end
                S_WR: begin
                    r_state <= S_DONE;
                    if (r_cmd == CMD_ADD) begin
                        r_res.hit <= r_found;
                        if (!r_found) begin
                            if (mem_we) begin
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_res.status <= ST_FULL;
                            end
                        end
                    end else if (r_cmd == CMD_LOOKUP) begin
                        r_res.hit <= r_found;
                    end
                end
                S_DONE: begin
                    r_res.occupancy <= 9'(r_count);
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.status    <= r_res.status;
            r_out.hit       <= r_res.hit;
            r_out.occupancy <= 9'(r_count);
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.status    = r_out.status;
    assign o_res.hit       = r_out.hit;
    assign o_res.occupancy = r_out.occupancy;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(ENTRIES))
        else $error("occupancy beyond table size");

    a_acc_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("accepted item did not start");

    a_count_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |=> $stable(r_count))
        else $error("occupancy changed outside an item");

    a_write_in_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_state != S_IDLE && r_state != S_DONE)
        else $error("memory written while idle");

endmodule

### sv/tkb_mem.sv
module tkb_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8,
    parameter int unsigned DW    = 129
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### tb/ttl_key_blacklist_table_test.sv
`timescale 1ns / 1ps

module ttl_key_blacklist_table_test;
    import tkb_pkg::*;

    localparam int unsigned SLOTS      = 256;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam logic [1:0]  REG_NONE   = 2'd3;
    localparam int unsigned DRAIN_WAIT = SLOTS + 40;

    typedef struct {
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [31:0] vsize;
        logic [31:0] now;
    } t_req;

    logic i_clk;
    logic i_rst_n;

    tkb_cmd_if in_if();
    tkb_res_if res_if();
    tkb_cfg_if cfg_if();

    ttl_key_blacklist_table #(.ENTRIES(SLOTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_res   (res_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // shadow table and configuration
    logic        tbl_valid [SLOTS];
    logic [63:0] tbl_key   [SLOTS];
    logic [31:0] tbl_expiry[SLOTS];
    logic [31:0] tbl_size  [SLOTS];
    logic [8:0]  tbl_count;
    logic [8:0]  lim_cfg;
    logic [3:0]  kbytes_cfg;
    logic [31:0] ttl_cfg;

    t_req        pending_reqs[$];
    t_result     expected_results[$];
    int          idle_mode;
    int          issued_cnt, accepted_cnt, checked_cnt, error_cnt;
    int          hold_gen, hold_seen, hold_left;
    int          n_hits, n_full, n_swept;

    // key pool for repeats
    logic [63:0] key_pool[16];
    logic [31:0] clock_s;

    function automatic logic [63:0] cmp_mask(input logic [3:0] kb);
        int nb;
        nb = (kb < 1) ? 1 : kb;
        if (nb >= 8) return '1;
        return (64'd1 << (8 * nb)) - 64'd1;
    endfunction

    function automatic int find_slot(input logic [63:0] k);
        logic [63:0] m;
        m = cmp_mask(kbytes_cfg);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i] && ((tbl_key[i] ^ k) & m) == 64'd0) return i;
        return -1;
    endfunction

    // table update for one beat, returns the expected result
    function automatic t_result apply_request(input t_req r);
        t_result     res;
        int          idx;
        int          limit;
        logic [31:0] exp_t;
        res = '0;
        limit = (lim_cfg > SLOTS) ? SLOTS : lim_cfg;
        case (r.cmd)
            CMD_ADD: begin
                exp_t = r.now + ttl_cfg;
                idx = find_slot(r.key);
                if (idx >= 0) begin
                    res.hit = 1'b1;
                    tbl_size[idx] = r.vsize;
                    tbl_expiry[idx] = exp_t;
                end else if (tbl_count >= limit) begin
                    res.status = ST_FULL;
                end else begin
                    idx = -1;
                    for (int i = 0; i < SLOTS && idx < 0; i++)
                        if (!tbl_valid[i]) idx = i;
                    if (idx < 0) res.status = ST_FULL;
                    else begin
                        tbl_valid[idx] = 1'b1;
                        tbl_key[idx] = r.key;
                        tbl_size[idx] = r.vsize;
                        tbl_expiry[idx] = exp_t;
                        tbl_count++;
                    end
                end
            end
            CMD_LOOKUP: res.hit = (find_slot(r.key) >= 0);
            CMD_SWEEP: begin
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_valid[i] && tbl_expiry[i] <= r.now) begin
                        tbl_valid[i] = 1'b0;
                        if (tbl_count > 0) tbl_count--;
                    end
            end
            default: ;
        endcase
        res.occupancy = tbl_count;
        return res;
    endfunction

    // accepted beats: command, configuration and result
    always @(posedge i_clk) begin
        t_req    r;
        t_result want;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    REG_MAX_ENTRIES:    lim_cfg = cfg_if.data[8:0];
                    REG_KEY_BYTES:      kbytes_cfg = cfg_if.data[3:0];
                    REG_EXPIRE_SECONDS: ttl_cfg = cfg_if.data;
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                r.cmd = in_if.cmd;
                r.key = in_if.key;
                r.vsize = in_if.value_size;
                r.now = in_if.now;
                want = apply_request(r);
                if (want.hit) n_hits++;
                if (want.status) n_full++;
                if (r.cmd == CMD_SWEEP) n_swept++;
                expected_results.push_back(want);
                accepted_cnt++;
            end
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    error_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (res_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_if.status);
                        error_cnt++;
                    end
                    if (res_if.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, res_if.hit);
                        error_cnt++;
                    end
                    if (res_if.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, res_if.occupancy);
                        error_cnt++;
                    end
                end
                checked_cnt++;
            end
        end
    end

    // command driver
    always @(negedge i_clk) begin
        t_req r;
        bit   gap;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (issued_cnt == accepted_cnt) begin
            gap = (idle_mode == 1) ? ($urandom_range(0, 99) < 48) :
                  (idle_mode == 3) ? ($urandom_range(0, 99) < 29) : 1'b0;
            if (pending_reqs.size() > 0 && !gap) begin
                r = pending_reqs.pop_front();
                in_if.cmd <= r.cmd;
                in_if.key <= r.key;
                in_if.value_size <= r.vsize;
                in_if.now <= r.now;
                in_if.valid <= 1'b1;
                issued_cnt++;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result receiver, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_gen != hold_seen) begin
            hold_seen = hold_gen;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (idle_mode == 2) begin
            res_if.ready <= ($urandom_range(0, 99) >= 48);
        end else if (idle_mode == 3) begin
            res_if.ready <= ($urandom_range(0, 99) >= 29);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    task automatic push_req(input logic [1:0] c, input logic [63:0] k,
                            input logic [31:0] s, input logic [31:0] t);
        t_req r;
        r.cmd = c;
        r.key = k;
        r.vsize = s;
        r.now = t;
        pending_reqs.push_back(r);
    endtask

    // mostly repeated keys, sometimes with upper bytes disturbed
    task automatic push_random(input int n);
        logic [1:0]  c;
        logic [63:0] k;
        int          roll, p;
        for (int j = 0; j < n; j++) begin
            roll = $urandom_range(0, 99);
            c = (roll < 50) ? CMD_ADD : (roll < 80) ? CMD_LOOKUP :
                (roll < 95) ? CMD_SWEEP : CMD_UNUSED;
            p = $urandom_range(0, 15);
            if ($urandom_range(0, 99) < 70) begin
                k = key_pool[p];
                if ($urandom_range(0, 99) < 30) k[63:32] = $urandom();
            end else begin
                k = {$urandom(), $urandom()};
                key_pool[p] = k;
            end
            if ($urandom_range(0, 99) < 5) clock_s = $urandom();
            else clock_s = clock_s + $urandom_range(0, 20);
            push_req(c, k, $urandom(), clock_s);
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || issued_cnt != accepted_cnt ||
               expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_if.index <= idx;
        cfg_if.data <= val;
        cfg_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] lim, input logic [31:0] kb,
                              input logic [31:0] ttl);
        drain();
        write_reg(REG_MAX_ENTRIES, lim);
        write_reg(REG_KEY_BYTES, kb);
        write_reg(REG_EXPIRE_SECONDS, ttl);
    endtask

    // run limit
    initial begin
        #200ms;
        $display("** ttl_key_blacklist_table: FAILED **");
        $finish;
    end

    // stimulus sequence
    initial begin
        in_if.valid = 1'b0;
        in_if.cmd = CMD_ADD;
        in_if.key = '0;
        in_if.value_size = '0;
        in_if.now = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_MAX_ENTRIES;
        cfg_if.data = '0;
        idle_mode = 0;
        {issued_cnt, accepted_cnt, checked_cnt, error_cnt} = '0;
        {hold_gen, hold_seen, hold_left} = '0;
        {n_hits, n_full, n_swept} = '0;
        clock_s = 32'd1000;
        lim_cfg = 9'd256;
        kbytes_cfg = 4'd4;
        ttl_cfg = 32'd0;
        tbl_count = '0;
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        for (int i = 0; i < 16; i++) key_pool[i] = {$urandom(), $urandom()};
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, field extremes, refresh, unused command, sweeps
        push_req(CMD_LOOKUP, '1, '0, '0);
        push_req(CMD_ADD, '1, '1, '1);
        push_req(CMD_ADD, '0, '0, '0);
        push_req(CMD_LOOKUP, 64'hFFFF_FFFF_0000_0000, '0, '0);
        push_req(CMD_LOOKUP, 64'h0000_0000_FFFF_FFFF, '0, '0);
        push_req(CMD_ADD, 64'h1234_5678_FFFF_FFFF, 32'hA5A5_5A5A, 32'd5);
        push_req(CMD_UNUSED, '1, '1, '1);
        push_req(CMD_ADD, 64'hDEAD_BEEF_0102_0304, 32'h1, 32'h8000_0000);
        push_req(CMD_SWEEP, '0, '0, 32'd4);
        push_req(CMD_LOOKUP, '1, '0, '0);
        push_req(CMD_SWEEP, '0, '0, '1);
        push_req(CMD_LOOKUP, '0, '0, '0);
        push_req(CMD_ADD, 64'h8000_0000_0000_0001, '1, 32'd10);
        set_config(32'd1, 32'd4, 32'd100);
        write_reg(REG_NONE, '1);
        push_req(CMD_ADD, 64'h55, '0, 32'd10);
        push_req(CMD_ADD, 64'h8000_0000_0000_0001, '0, 32'd20);
        push_req(CMD_SWEEP, '0, '0, 32'd119);
        push_req(CMD_SWEEP, '0, '0, 32'd120);
        // expiry wrapping past the top of the range
        set_config(32'd256, 32'd8, '1);
        push_req(CMD_ADD, 64'hAA, '0, 32'd2);
        push_req(CMD_SWEEP, '0, '0, 32'd0);
        push_req(CMD_SWEEP, '0, '0, 32'd1);

        // random phases over several settings and idling patterns
        set_config(32'd256, 32'd8, 32'd100);
        push_random(250);
        set_config(32'd0, 32'd1, '1);
        idle_mode = 1;
        push_random(60);
        // fill past the table size, with a long receiver hold-off
        set_config(32'd300, 32'd2, 32'd50);
        idle_mode = 2;
        for (int i = 0; i < 270; i++)
            push_req(CMD_ADD, {$urandom(), 16'h0, 16'(i)}, $urandom(), clock_s + i);
        hold_gen++;
        set_config(32'd20, 32'd0, 32'd1000);
        idle_mode = 3;
        push_random(200);
        set_config(32'd256, 32'd9, 32'd0);
        idle_mode = 0;
        push_random(100);
        idle_mode = 1;
        push_random(100);
        set_config(32'd8, 32'd5, 32'd10);
        idle_mode = 2;
        push_random(150);
        drain();

        $display("covered %0d beats checked, %0d hits, %0d table-full adds, %0d sweeps",
                 checked_cnt, n_hits, n_full, n_swept);
        if (error_cnt == 0 && expected_results.size() == 0)
            $display("** ttl_key_blacklist_table: PASSED **");
        else
            $display("** ttl_key_blacklist_table: FAILED **");
        $finish;
    end

endmodule

### ttl_key_blacklist_table.f
sv/tkb_pkg.sv
sv/tkb_ifs.sv
sv/tkb_mem.sv
sv/ttl_key_blacklist_table.sv
tb/ttl_key_blacklist_table_test.sv
